FILE: rtl/gfse_pkg.sv
// shared constants, types, microcode table and symbol encoding for the first-set engine
package gfse_pkg;

   localparam int MAX_RULES  = 16;
   localparam int NT_COUNT   = 26;
   localparam int MAX_OUT    = 16;
   localparam int SYM_W      = 7;
   localparam int SET_W      = 30;
   localparam int HEAD_W     = 6;
   localparam int NT_W       = 5;
   localparam int IDX_W      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W      = $clog2(MAX_RULES + 1);
   localparam int EMIT_W     = $clog2(MAX_OUT + 1);
   localparam int CMP_W      = (CNT_W > EMIT_W) ? CNT_W : EMIT_W;
   localparam int PASS_LIMIT = NT_COUNT + 2;
   localparam int PASS_W     = $clog2(PASS_LIMIT + 1);
   localparam int PC_W       = 4;

   localparam logic [SYM_W-1:0] ASCII_UPPER_A = 7'h41;
   localparam logic [SYM_W-1:0] ASCII_UPPER_Z = 7'h5A;
   localparam logic [SYM_W-1:0] ASCII_LOWER_A = 7'h61;
   localparam logic [SYM_W-1:0] ASCII_LOWER_Z = 7'h7A;
   localparam logic [SYM_W-1:0] ASCII_PLUS    = 7'h2B;
   localparam logic [SYM_W-1:0] ASCII_STAR    = 7'h2A;
   localparam logic [SYM_W-1:0] ASCII_LPAREN  = 7'h28;
   localparam logic [SYM_W-1:0] ASCII_RPAREN  = 7'h29;

   localparam logic [HEAD_W-1:0] HEAD_PLUS     = 6'd26;
   localparam logic [HEAD_W-1:0] HEAD_STAR     = 6'd27;
   localparam logic [HEAD_W-1:0] HEAD_LPAREN   = 6'd28;
   localparam logic [HEAD_W-1:0] HEAD_RPAREN   = 6'd29;
   localparam logic [HEAD_W-1:0] HEAD_TERM_END = 6'd30;
   localparam logic [HEAD_W-1:0] HEAD_NT_BASE  = 6'd32;
   localparam logic [HEAD_W-1:0] HEAD_NT_END   = HEAD_NT_BASE + HEAD_W'(NT_COUNT);
   localparam logic [HEAD_W-1:0] HEAD_OTHER    = 6'd63;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_PASS_START,
      OP_RD_RULE,
      OP_RD_SET,
      OP_UPDATE,
      OP_PASS_END,
      OP_EM_START,
      OP_EM_OUT,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_EMPTY,
      C_MORE_RULES,
      C_AGAIN
   } cond_type;

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_WAIT       = 4'd0;
   localparam pc_type PC_PASS_START = 4'd1;
   localparam pc_type PC_RD_RULE    = 4'd2;
   localparam pc_type PC_RD_SET     = 4'd3;
   localparam pc_type PC_UPDATE     = 4'd4;
   localparam pc_type PC_PASS_END   = 4'd5;
   localparam pc_type PC_EM_START   = 4'd6;
   localparam pc_type PC_EM_RD_RULE = 4'd7;
   localparam pc_type PC_EM_RD_SET  = 4'd8;
   localparam pc_type PC_EM_OUT     = 4'd9;
   localparam pc_type PC_CLEAR      = 4'd10;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   // control store: a taken condition jumps to target, otherwise fall through
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      unique case (pc)
         PC_WAIT:       w = '{OP_WAIT,       C_EMPTY,      PC_CLEAR};
         PC_PASS_START: w = '{OP_PASS_START, C_NONE,       PC_WAIT};
         PC_RD_RULE:    w = '{OP_RD_RULE,    C_NONE,       PC_WAIT};
         PC_RD_SET:     w = '{OP_RD_SET,     C_NONE,       PC_WAIT};
         PC_UPDATE:     w = '{OP_UPDATE,     C_MORE_RULES, PC_RD_RULE};
         PC_PASS_END:   w = '{OP_PASS_END,   C_AGAIN,      PC_PASS_START};
         PC_EM_START:   w = '{OP_EM_START,   C_NONE,       PC_WAIT};
         PC_EM_RD_RULE: w = '{OP_RD_RULE,    C_NONE,       PC_WAIT};
         PC_EM_RD_SET:  w = '{OP_RD_SET,     C_NONE,       PC_WAIT};
         PC_EM_OUT:     w = '{OP_EM_OUT,     C_MORE_RULES, PC_EM_RD_RULE};
         PC_CLEAR:      w = '{OP_CLEAR,      C_ALWAYS,     PC_WAIT};
         default:       w = '{OP_CLEAR,      C_ALWAYS,     PC_WAIT};
      endcase
      return w;
   endfunction

   function automatic logic is_upper(input logic [SYM_W-1:0] s);
      return (s >= ASCII_UPPER_A) && (s <= ASCII_UPPER_Z);
   endfunction

   function automatic logic [HEAD_W-1:0] encode_head(input logic [SYM_W-1:0] s);
      logic [SYM_W-1:0] d;
      logic [HEAD_W-1:0] code;
      d    = '0;
      code = HEAD_OTHER;
      if ((s >= ASCII_LOWER_A) && (s <= ASCII_LOWER_Z)) begin
         d    = s - ASCII_LOWER_A;
         code = d[HEAD_W-1:0];
      end else if (s == ASCII_PLUS) begin
         code = HEAD_PLUS;
      end else if (s == ASCII_STAR) begin
         code = HEAD_STAR;
      end else if (s == ASCII_LPAREN) begin
         code = HEAD_LPAREN;
      end else if (s == ASCII_RPAREN) begin
         code = HEAD_RPAREN;
      end else if (is_upper(s)) begin
         d    = s - ASCII_UPPER_A;
         code = HEAD_NT_BASE | {1'b0, d[NT_W-1:0]};
      end
      return code;
   endfunction

endpackage

FILE: rtl/gfse_ifs.sv
// request and result channel interfaces of the first-set engine
interface gfse_req_if;
   import gfse_pkg::*;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] lhs_symbol;
   logic [SYM_W-1:0] head_symbol;
   logic             last_rule;

   modport source (output valid, output lhs_symbol, output head_symbol, output last_rule,
                   input ready);
   modport sink (input valid, input lhs_symbol, input head_symbol, input last_rule,
                 output ready);
endinterface

interface gfse_rsp_if;
   import gfse_pkg::*;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] nonterminal;
   logic [SET_W-1:0] first_mask;
   logic             last_of_run;
   logic             rules_dropped;

   modport source (output valid, output nonterminal, output first_mask, output last_of_run,
                   output rules_dropped, input ready);
   modport sink (input valid, input nonterminal, input first_mask, input last_of_run,
                 input rules_dropped, output ready);
endinterface

FILE: rtl/grammar_first_set_engine_unit.sv
// FIRST-set engine: rule loader, microcoded closure sequencer and result emitter
//
// Productions arrive one request per cycle while the engine is waiting; each one with an
// uppercase left-hand side and room left is stored in the rule table in the cycle it is
// accepted. The request marked last starts the closure, run by a small control store
// stepping a single set-merge datapath: every pass reads each stored rule, reads its
// sets and updates, and passes repeat until no set changes (at most 28). Emission then
// takes a setup step and, per stored rule, a rule read, a set read and an output step
// that waits for a free result register when it emits, and a final step clears the
// grammar before requests are taken again; a last request with no stored rule goes
// straight to clearing. Results leave through an output register, so the last one
// may still be waiting while the next grammar loads. Rules past the table size are
// dropped and reported on every result of that grammar.
module grammar_first_set_engine_unit (
   input  logic      clock,
   input  logic      reset,
   gfse_req_if.sink  req_if,
   gfse_rsp_if.source rsp_if
);
   import gfse_pkg::*;

   // sequencer
   pc_type    pc_ff, pc_in;
   ucode_type uc;
   logic      hold;
   logic      take;

   // rule storage
   logic [NT_W-1:0]     lhs_mem  [MAX_RULES];
   logic [HEAD_W-1:0]   head_mem [MAX_RULES];
   logic [MAX_RULES-1:0] first_ff;
   logic [SET_W-1:0]    set_mem  [NT_COUNT];

   logic [NT_COUNT-1:0] seen_ff, seen_in;
   logic [NT_COUNT-1:0] set_valid_ff, set_valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    dcnt_ff, dcnt_in;
   logic                over_ff, over_in;
   logic [IDX_W-1:0]    r_ff, r_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic                changed_ff, changed_in;
   logic [EMIT_W-1:0]   n_ff, n_in;

   logic [NT_W-1:0]     lhs_rd_ff;
   logic [HEAD_W-1:0]   head_rd_ff;
   logic [SET_W-1:0]    dst_rd_ff;
   logic [SET_W-1:0]    src_rd_ff;

   logic                rsp_valid_ff;
   logic [SYM_W-1:0]    rsp_nt_ff;
   logic [SET_W-1:0]    rsp_mask_ff;
   logic                rsp_last_ff;
   logic                rsp_drop_ff;

   // load path
   logic             req_fire;
   logic             lhs_ok;
   logic [SYM_W-1:0] lhs_diff;
   logic [NT_W-1:0]  lhs_idx;
   logic             room;
   logic             store;

   // merge datapath
   logic             src_is_nt;
   logic             src_is_term;
   logic [NT_W-1:0]  src_idx;
   logic [SET_W-1:0] old_set;
   logic [SET_W-1:0] add_set;
   logic [SET_W-1:0] new_set;
   logic             differ;
   logic             set_we;

   // emission
   logic [CNT_W-1:0] r_next_cnt;
   logic             more_rules;
   logic             again;
   logic             emit;
   logic             out_free;
   logic             rsp_load;
   logic [CMP_W-1:0] emit_total;
   logic [CMP_W-1:0] n_next_cmp;

   assign uc = ucode_rom(pc_ff);

   assign req_if.ready = (uc.op == OP_WAIT);
   assign req_fire     = req_if.valid && req_if.ready;
   assign lhs_ok       = is_upper(req_if.lhs_symbol);
   assign lhs_diff     = req_if.lhs_symbol - ASCII_UPPER_A;
   assign lhs_idx      = lhs_ok ? lhs_diff[NT_W-1:0] : '0;
   assign room         = (count_ff < CNT_W'(MAX_RULES));
   assign store        = req_fire && lhs_ok && room;

   assign src_is_nt   = (head_rd_ff >= HEAD_NT_BASE) && (head_rd_ff < HEAD_NT_END);
   assign src_is_term = (head_rd_ff < HEAD_TERM_END);
   assign src_idx     = src_is_nt ? head_rd_ff[NT_W-1:0] : '0;

   // an entry with no valid bit still holds a stale set from an earlier grammar
   always_comb begin
      old_set = set_valid_ff[lhs_rd_ff] ? dst_rd_ff : '0;
      add_set = '0;
      if (src_is_term) begin
         add_set = SET_W'(1) << head_rd_ff;
      end else if (src_is_nt && set_valid_ff[src_idx]) begin
         add_set = src_rd_ff;
      end
      new_set = old_set | add_set;
      differ  = (new_set != old_set);
   end

   assign set_we = (uc.op == OP_UPDATE) && differ;

   assign r_next_cnt = CNT_W'(r_ff) + CNT_W'(1);
   assign more_rules = (r_next_cnt != count_ff);
   assign again      = changed_ff && (pass_ff < PASS_W'(PASS_LIMIT));

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign emit       = first_ff[r_ff] && (n_ff < EMIT_W'(MAX_OUT));
   assign rsp_load   = (uc.op == OP_EM_OUT) && emit && out_free;
   assign emit_total = (CMP_W'(dcnt_ff) > CMP_W'(MAX_OUT)) ? CMP_W'(MAX_OUT) : CMP_W'(dcnt_ff);
   assign n_next_cmp = CMP_W'(n_ff) + CMP_W'(1);

   // step counter
   always_comb begin
      hold = 1'b0;
      if (uc.op == OP_WAIT) begin
         hold = !(req_fire && req_if.last_rule);
      end else if (uc.op == OP_EM_OUT) begin
         hold = emit && !out_free;
      end
      case (uc.cond)
         C_NONE:       take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_EMPTY:      take = (count_in == '0);
         C_MORE_RULES: take = more_rules;
         C_AGAIN:      take = again;
         default:      take = 1'b0;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = uc.target;
      end else begin
         pc_in = pc_ff + pc_type'(1);
      end
   end

   // datapath control
   always_comb begin
      seen_in      = seen_ff;
      set_valid_in = set_valid_ff;
      count_in     = count_ff;
      dcnt_in      = dcnt_ff;
      over_in      = over_ff;
      r_in         = r_ff;
      pass_in      = pass_ff;
      changed_in   = changed_ff;
      n_in         = n_ff;
      unique case (uc.op) inside
         OP_WAIT: begin
            pass_in = '0;
            if (store) begin
               count_in         = count_ff + CNT_W'(1);
               seen_in[lhs_idx] = 1'b1;
               if (!seen_ff[lhs_idx]) begin
                  dcnt_in = dcnt_ff + CNT_W'(1);
               end
            end else if (req_fire && lhs_ok) begin
               over_in = 1'b1;
            end
         end
         OP_PASS_START: begin
            changed_in = 1'b0;
            r_in       = '0;
            pass_in    = pass_ff + PASS_W'(1);
         end
         OP_RD_RULE, OP_RD_SET, OP_PASS_END: begin
         end
         OP_UPDATE: begin
            if (differ) begin
               changed_in              = 1'b1;
               set_valid_in[lhs_rd_ff] = 1'b1;
            end
            if (more_rules) begin
               r_in = r_ff + IDX_W'(1);
            end
         end
         OP_EM_START: begin
            r_in = '0;
            n_in = '0;
         end
         OP_EM_OUT: begin
            if (!hold) begin
               if (emit) begin
                  n_in = n_ff + EMIT_W'(1);
               end
               if (more_rules) begin
                  r_in = r_ff + IDX_W'(1);
               end
            end
         end
         OP_CLEAR: begin
            count_in     = '0;
            dcnt_in      = '0;
            over_in      = 1'b0;
            seen_in      = '0;
            set_valid_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         seen_ff      <= '0;
         set_valid_ff <= '0;
         count_ff     <= '0;
         dcnt_ff      <= '0;
         over_ff      <= 1'b0;
         r_ff         <= '0;
         pass_ff      <= '0;
         changed_ff   <= 1'b0;
         n_ff         <= '0;
      end else begin
         pc_ff        <= pc_in;
         seen_ff      <= seen_in;
         set_valid_ff <= set_valid_in;
         count_ff     <= count_in;
         dcnt_ff      <= dcnt_in;
         over_ff      <= over_in;
         r_ff         <= r_in;
         pass_ff      <= pass_in;
         changed_ff   <= changed_in;
         n_ff         <= n_in;
      end
   end

   // rule table, with a flag for the first rule of each nonterminal
   always_ff @(posedge clock) begin
      if (store) begin
         lhs_mem[count_ff[IDX_W-1:0]]  <= lhs_idx;
         head_mem[count_ff[IDX_W-1:0]] <= encode_head(req_if.head_symbol);
         first_ff[count_ff[IDX_W-1:0]] <= !seen_ff[lhs_idx];
      end
      if (uc.op == OP_RD_RULE) begin
         lhs_rd_ff  <= lhs_mem[r_ff];
         head_rd_ff <= head_mem[r_ff];
      end
   end

   // set store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (set_we) begin
         set_mem[lhs_rd_ff] <= new_set;
      end
      if (uc.op == OP_RD_SET) begin
         dst_rd_ff <= set_mem[lhs_rd_ff];
         src_rd_ff <= set_mem[src_idx];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_nt_ff   <= ASCII_UPPER_A + SYM_W'(lhs_rd_ff);
         rsp_mask_ff <= old_set;
         rsp_last_ff <= (n_next_cmp == emit_total);
         rsp_drop_ff <= over_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.nonterminal   = rsp_nt_ff;
   assign rsp_if.first_mask    = rsp_mask_ff;
   assign rsp_if.last_of_run   = rsp_last_ff;
   assign rsp_if.rules_dropped = rsp_drop_ff;

endmodule

FILE: rtl/gfse_checker.sv
// port-level checks of the first-set engine and their bind to the top level
module gfse_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [gfse_pkg::SYM_W-1:0] rsp_nonterminal,
   input logic [gfse_pkg::SET_W-1:0] rsp_first_mask,
   input logic                      rsp_last_of_run
);
   import gfse_pkg::*;

   // no result survives a reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_nt_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nonterminal >= ASCII_UPPER_A) && (rsp_nonterminal <= ASCII_UPPER_Z))
      else $error("nonterminal out of range");

   // no new request while a run is still being emitted
   a_no_load_mid_run : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("request taken in the middle of a run");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nonterminal)
                                  && $stable(rsp_first_mask) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

endmodule

bind grammar_first_set_engine_unit gfse_checker u_gfse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_nonterminal (rsp_if.nonterminal),
   .rsp_first_mask  (rsp_if.first_mask),
   .rsp_last_of_run (rsp_if.last_of_run)
);
